>>> design/sfh_pkg.sv
// Shared types and constants for the symbol frequency histogram.
package sfh_pkg;

    localparam int BINS_DEF       = 256;
    localparam int COUNT_BITS_DEF = 32;
    localparam int SYM_W          = 16;
    localparam int OUT_COUNT_W    = 32;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 56;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_PARTIAL = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    typedef enum logic [1:0] {
        OP_REPORT,
        OP_COUNT,
        OP_READ,
        OP_CLEAR
    } t_op_kind;

    typedef struct packed {
        t_op_kind             kind;
        logic [SYM_W-1:0]     key;
        logic [1:0]           status;
    } t_op;

endpackage

>>> design/sfh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/sfh_front.sv
// Front end: takes input beats, assembles symbols and classifies them into ops.
module sfh_front #(
    parameter int BINS = sfh_pkg::BINS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_wdata,
    input  logic                i_valid,
    input  logic [1:0]          i_cmd,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic [7:0]          i_bin_index,
    input  logic                i_enable,
    input  logic                i_op_full,
    output logic                o_ready,
    output logic                o_op_push,
    output sfh_pkg::t_op        o_op
);

    localparam logic [sfh_pkg::SYM_W:0] BINS_L = (sfh_pkg::SYM_W + 1)'(BINS);

    logic [1:0]               r_symbol_bytes;
    logic [1:0]               n_symbol_bytes;
    logic [7:0]               r_partial;
    logic [7:0]               n_partial;
    logic                     r_pos;
    logic                     n_pos;
    logic                     accept;
    logic                     wide;
    logic [sfh_pkg::SYM_W-1:0] sym;
    logic [sfh_pkg::SYM_W-1:0] idx;
    sfh_pkg::t_op             op;

    assign o_ready = i_enable && !i_op_full;
    assign accept  = i_valid && o_ready;
    assign wide    = r_symbol_bytes[1];
    assign sym     = r_pos ? {i_data_byte, r_partial} : {8'h00, i_data_byte};
    assign idx     = {8'h00, i_bin_index};

    always_comb begin
        n_symbol_bytes = i_cfg_we ? i_cfg_wdata : r_symbol_bytes;
        n_partial      = r_partial;
        n_pos          = r_pos;
        op.kind        = sfh_pkg::OP_REPORT;
        op.key         = '0;
        op.status      = sfh_pkg::ST_OK;
        unique case (i_cmd)
            sfh_pkg::CMD_DATA: begin
                if (r_pos || !wide) begin
                    if ({1'b0, sym} < BINS_L) begin
                        op.kind = sfh_pkg::OP_COUNT;
                        op.key  = sym;
                    end else begin
                        op.status = sfh_pkg::ST_RANGE;
                    end
                    if (accept) begin
                        n_pos     = 1'b0;
                        n_partial = '0;
                    end
                end else if (i_last_byte) begin
                    op.status = sfh_pkg::ST_PARTIAL;
                    if (accept) begin
                        n_pos     = 1'b0;
                        n_partial = '0;
                    end
                end else if (accept) begin
                    n_pos     = 1'b1;
                    n_partial = i_data_byte;
                end
            end
            sfh_pkg::CMD_CLEAR: begin
                op.kind = sfh_pkg::OP_CLEAR;
            end
            sfh_pkg::CMD_READ: begin
                if ({1'b0, idx} < BINS_L) begin
                    op.kind = sfh_pkg::OP_READ;
                    op.key  = idx;
                end else begin
                    op.status = sfh_pkg::ST_RANGE;
                end
            end
            default: begin
                op.kind = sfh_pkg::OP_REPORT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_bytes <= 2'd1;
            r_partial      <= '0;
            r_pos          <= 1'b0;
        end else begin
            r_symbol_bytes <= n_symbol_bytes;
            r_partial      <= n_partial;
            r_pos          <= n_pos;
        end
    end

    assign o_op_push = accept;
    assign o_op      = op;

endmodule

>>> design/sfh_queue.sv
// Short op queue between the front end and the bin update engine.
module sfh_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  sfh_pkg::t_op i_din,
    input  logic         i_pop,
    output sfh_pkg::t_op o_dout,
    output logic         o_full,
    output logic         o_empty
);

    sfh_pkg::t_op                r_slot [sfh_pkg::QUEUE_DEPTH];
    logic [sfh_pkg::QPTR_W-1:0]  r_wptr;
    logic [sfh_pkg::QPTR_W-1:0]  r_rptr;
    logic [sfh_pkg::QCNT_W-1:0]  r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_cnt == sfh_pkg::QCNT_W'(sfh_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_dout  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> design/sfh_back.sv
// Back end: bin read-modify-write, clear sweeps, minimum tracking, result register.
module sfh_back #(
    parameter int BINS       = sfh_pkg::BINS_DEF,
    parameter int COUNT_BITS = sfh_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_op_valid,
    input  sfh_pkg::t_op                     i_op,
    output logic                             o_op_pop,
    output logic                             o_init_done,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [sfh_pkg::OUT_COUNT_W-1:0]  o_bin_count,
    output logic [sfh_pkg::SYM_W-1:0]        o_min_symbol,
    output logic                             o_min_valid,
    output logic [1:0]                       o_status
);

    localparam int IDX_W = $clog2(BINS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BINS - 1);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_MEM,
        S_CLEAR
    } t_state;

    t_state                           r_state, n_state;
    logic [IDX_W-1:0]                 r_addr, n_addr;
    sfh_pkg::t_op                     r_op, n_op;
    logic [sfh_pkg::SYM_W-1:0]        r_min, n_min;
    logic                             r_known, n_known;
    logic                             r_out_valid, n_out_valid;
    logic [sfh_pkg::OUT_COUNT_W-1:0]  r_out_count, n_out_count;
    logic [sfh_pkg::SYM_W-1:0]        r_out_min, n_out_min;
    logic                             r_out_known, n_out_known;
    logic [1:0]                       r_out_status, n_out_status;

    logic                             ram_we;
    logic [IDX_W-1:0]                 ram_waddr;
    logic [COUNT_BITS-1:0]            ram_wdata;
    logic [IDX_W-1:0]                 ram_raddr;
    logic [COUNT_BITS-1:0]            ram_rdata;
    logic                             slot_free;
    logic                             sat;
    logic [63:0]                      rd_wide;
    logic [sfh_pkg::SYM_W-1:0]        upd_min;

    sfh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_free = !r_out_valid || i_out_ready;
    assign sat       = (ram_rdata == '1);
    assign rd_wide   = 64'(ram_rdata);
    assign upd_min   = (!r_known || r_op.key < r_min) ? r_op.key : r_min;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_op         = r_op;
        n_min        = r_min;
        n_known      = r_known;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_count  = r_out_count;
        n_out_min    = r_out_min;
        n_out_known  = r_out_known;
        n_out_status = r_out_status;
        o_op_pop     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = '0;
        ram_raddr    = i_op.key[IDX_W-1:0];
        unique case (r_state)
            S_INIT: begin
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_op_valid && slot_free) begin
                    o_op_pop = 1'b1;
                    n_op     = i_op;
                    unique case (i_op.kind)
                        sfh_pkg::OP_REPORT: begin
                            n_out_valid  = 1'b1;
                            n_out_count  = '0;
                            n_out_min    = r_min;
                            n_out_known  = r_known;
                            n_out_status = i_op.status;
                        end
                        sfh_pkg::OP_COUNT, sfh_pkg::OP_READ: begin
                            n_state = S_MEM;
                        end
                        sfh_pkg::OP_CLEAR: begin
                            n_min   = '0;
                            n_known = 1'b0;
                            n_addr  = '0;
                            n_state = S_CLEAR;
                        end
                    endcase
                end
            end
            S_MEM: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
                if (r_op.kind == sfh_pkg::OP_COUNT) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_op.key[IDX_W-1:0];
                    ram_wdata    = sat ? ram_rdata : ram_rdata + COUNT_BITS'(1);
                    n_min        = upd_min;
                    n_known      = 1'b1;
                    n_out_count  = '0;
                    n_out_min    = upd_min;
                    n_out_known  = 1'b1;
                    n_out_status = sat ? sfh_pkg::ST_SAT : sfh_pkg::ST_OK;
                end else begin
                    n_out_count  = (rd_wide[63:32] != '0) ? '1 : rd_wide[31:0];
                    n_out_min    = r_min;
                    n_out_known  = r_known;
                    n_out_status = sfh_pkg::ST_OK;
                end
            end
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_addr       = '0;
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_count  = '0;
                    n_out_min    = '0;
                    n_out_known  = 1'b0;
                    n_out_status = sfh_pkg::ST_OK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_min       <= '0;
            r_known     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_min       <= n_min;
            r_known     <= n_known;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_out_count  <= n_out_count;
        r_out_min    <= n_out_min;
        r_out_known  <= n_out_known;
        r_out_status <= n_out_status;
    end

    assign o_init_done  = (r_state != S_INIT);
    assign o_out_valid  = r_out_valid;
    assign o_bin_count  = r_out_count;
    assign o_min_symbol = r_out_min;
    assign o_min_valid  = r_out_known;
    assign o_status     = r_out_status;

endmodule

>>> design/symbol_frequency_histogram_top.sv
// Top level of the symbol frequency histogram.
//
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata, tlast, tuser
// m_axis    out  tvalid/tready         tdata, tuser
// cfg       in   i_cfg_we              i_cfg_wdata (symbol bytes)
//
// Front takes one beat per cycle into a 2-entry op queue unless the queue is full;
// the back end retires one op at a time: a report-only beat is answered from idle,
// a count or read reads its bin (a count then writes it back), a clear sweeps all
// bins to zero. After reset the bin RAM is swept to zero with s_axis_tready low.
// Result register holds one beat; the back end takes its next op only once
// that beat is taken or being taken, so an m_axis stall backs up into the queue.
module symbol_frequency_histogram_top #(
    parameter int BINS       = sfh_pkg::BINS_DEF,
    parameter int COUNT_BITS = sfh_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] data_byte, [15:8] bin_index
    input  logic [sfh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    // [1:0] cmd
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] bin_count, [47:32] min_symbol, [48] min_valid, [55:49] zero
    output logic [sfh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]                      m_axis_tuser
);

    sfh_pkg::t_op                    push_op;
    sfh_pkg::t_op                    head_op;
    logic                            push;
    logic                            pop;
    logic                            q_full;
    logic                            q_empty;
    logic                            init_done;
    logic [sfh_pkg::OUT_COUNT_W-1:0] bin_count;
    logic [sfh_pkg::SYM_W-1:0]       min_symbol;
    logic                            min_valid;

    sfh_front #(
        .BINS (BINS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_cmd       (s_axis_tuser),
        .i_data_byte (s_axis_tdata[7:0]),
        .i_last_byte (s_axis_tlast),
        .i_bin_index (s_axis_tdata[15:8]),
        .i_enable    (init_done),
        .i_op_full   (q_full),
        .o_ready     (s_axis_tready),
        .o_op_push   (push),
        .o_op        (push_op)
    );

    sfh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (push_op),
        .i_pop   (pop),
        .o_dout  (head_op),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sfh_back #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (!q_empty),
        .i_op         (head_op),
        .o_op_pop     (pop),
        .o_init_done  (init_done),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_bin_count  (bin_count),
        .o_min_symbol (min_symbol),
        .o_min_valid  (min_valid),
        .o_status     (m_axis_tuser)
    );

    assign m_axis_tdata = {7'b0, min_valid, min_symbol, bin_count};

endmodule
